@@ rtl/core/rtpf_pkg.sv @@
// Shared constants and codes for the raster-to-page framebuffer port.
// No dependencies; the interfaces and the top level refer to this package.
`default_nettype none

package rtpf_pkg;

    // Default size of the page framebuffer
    localparam int MAX_WIDTH_DEF = 128;
    localparam int MAX_PAGES_DEF = 8;

    // Field widths of the request and response channels
    localparam int OFFSET_W = 10;
    localparam int DATA_W   = 8;
    localparam int PAGE_W   = 3;

    // Pixels in one raster byte, leftmost pixel mask
    localparam int          PIX_PER_BYTE = 8;
    localparam logic [7:0]  LEFT_PIXEL   = 8'h80;

    // Request function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Configuration register map
    localparam int         CFG_IDX_W     = 1;
    localparam int         CFG_DATA_W    = 8;
    localparam logic [0:0] CFG_WIDTH     = 1'd0;
    localparam logic [0:0] CFG_PAGES     = 1'd1;
    localparam logic [7:0] WIDTH_RST_VAL = 8'd128;
    localparam logic [3:0] PAGES_RST_VAL = 4'd8;

endpackage

`default_nettype wire

@@ rtl/core/rtpf_req_if.sv @@
// Request channel of the framebuffer port: valid/ready plus one raster access.
// Depends on rtpf_pkg for field widths.
`default_nettype none

interface rtpf_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [rtpf_pkg::OFFSET_W-1:0] byte_offset;
    logic [rtpf_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, func, byte_offset, write_data, input ready);
    modport sink   (input valid, func, byte_offset, write_data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rtpf_rsp_if.sv @@
// Response channel of the framebuffer port: valid/ready plus one result.
// Depends on rtpf_pkg for field widths.
`default_nettype none

interface rtpf_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [rtpf_pkg::DATA_W-1:0] read_data;
    logic [rtpf_pkg::PAGE_W-1:0] start_page;
    logic [rtpf_pkg::PAGE_W-1:0] end_page;
    logic                        out_of_range;

    modport source (output valid, read_data, start_page, end_page, out_of_range,
                    input ready);
    modport sink   (input valid, read_data, start_page, end_page, out_of_range,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/rtpf_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module rtpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_en,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_addr,
    input  wire [WIDTH-1:0]          i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One access per cycle: write, or read into the output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rtpf_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Splits a pixel index into row (quotient) and column (remainder).
`default_nettype none

module rtpf_div #(
    parameter int DW = 13,   // dividend / quotient width
    parameter int VW = 8     // divisor / remainder width
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire [DW-1:0]  i_dividend,
    input  wire [VW-1:0]  i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);

    localparam int CNTW = (DW > 1) ? $clog2(DW) : 1;

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [VW-1:0]   r_rem;
    logic [DW-1:0]   r_quo;

    logic [VW:0]     trial;
    logic            q_bit;
    logic [VW-1:0]   n_rem;

    // Trial subtract of the divisor from the partial remainder
    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        q_bit = (trial >= {1'b0, i_divisor});
        n_rem = q_bit ? VW'(trial - {1'b0, i_divisor}) : VW'(trial);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out at the top, quotient shifts in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DW-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < i_divisor))
        else $error("divider remainder not below divisor");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted mid-division");

endmodule

`default_nettype wire

@@ rtl/core/raster_to_page_framebuffer_port_top.sv @@
// Raster-to-page framebuffer port: top level with sequencer and pixel walker.
// Depends on rtpf_pkg, rtpf_req_if, rtpf_rsp_if, rtpf_div and rtpf_ram.
//
// Byte port onto a 1-bit-per-pixel page framebuffer (one byte = 8 vertical
// pixels of one column), presented as a row-major raster, MSB leftmost. After
// reset the framebuffer is zeroed by a clearing pass over all MAX_WIDTH *
// MAX_PAGES bytes (1024 by default), during which no request is accepted;
// config writes are taken at any time. One request is handled at a time. An
// in-range request passes the range check, then the divider stage (the
// bit-serial divider with a 13-bit quotient splits the first pixel index into
// row and column, and its result is picked up), then the page base is formed,
// then each pixel is read and then written or gathered through the
// single-port framebuffer RAM, then the response register is loaded and the
// sequencer returns to idle to take the next request. An out-of-range request
// goes from the range check straight to the response register. A new request
// is accepted while the previous response still waits at the output; a second
// finished response stalls the request side until the first one is taken.
`default_nettype none

module raster_to_page_framebuffer_port_top #(
    parameter int MAX_WIDTH = rtpf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_PAGES = rtpf_pkg::MAX_PAGES_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [rtpf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [rtpf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    rtpf_req_if.sink                           i_req,
    rtpf_rsp_if.source                         o_rsp
);

    localparam int DEPTH  = MAX_WIDTH * MAX_PAGES;
    localparam int AW     = $clog2(DEPTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int PW     = $clog2(MAX_PAGES + 1);
    localparam int LW     = WW + PW;
    localparam int CMPW   = (LW > rtpf_pkg::OFFSET_W) ? LW : rtpf_pkg::OFFSET_W;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int PGW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int DIVW   = rtpf_pkg::OFFSET_W + 3;
    localparam int DATW   = rtpf_pkg::DATA_W;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_DIV, S_BASE, S_RD, S_WR, S_FINISH
    } t_state;

    // Config registers
    logic [7:0]     r_width;
    logic [3:0]     r_pages;
    logic [WW-1:0]  w_eff;
    logic [PW-1:0]  p_eff;

    // Sequencer and walker state
    t_state                         r_state;
    logic [AW-1:0]                  r_clr;
    logic                           r_func;
    logic [rtpf_pkg::OFFSET_W-1:0]  r_offset;
    logic [DATW-1:0]                r_shift;
    logic [LW-1:0]                  r_limit;
    logic                           r_oor;
    logic [CW-1:0]                  r_col;
    logic [2:0]                     r_bit;
    logic [PGW-1:0]                 r_page;
    logic [AW-1:0]                  r_base;
    logic [2:0]                     r_k;
    logic [rtpf_pkg::PAGE_W-1:0]    r_start_page;
    logic [rtpf_pkg::PAGE_W-1:0]    r_end_page;

    // Output register
    logic                           r_out_valid;
    logic [DATW-1:0]                r_rd_data;
    logic [rtpf_pkg::PAGE_W-1:0]    r_out_first;
    logic [rtpf_pkg::PAGE_W-1:0]    r_out_last;
    logic                           r_out_oor;

    // Divider and RAM hookup
    logic             div_start;
    logic             div_done;
    logic [DIVW-1:0]  div_quot;
    logic [WW-1:0]    div_rem;
    logic             ram_en;
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [DATW-1:0]  ram_wdata;
    logic [DATW-1:0]  ram_rdata;

    logic [AW-1:0]    pix_addr;
    logic [DATW-1:0]  bit_mask;
    logic [DATW-1:0]  merged;
    logic [LW-1:0]    limit;
    logic             slot_free;
    logic             is_write;

    // Effective geometry: zero counts as one, large values saturate
    always_comb begin
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        if (r_pages == '0) begin
            p_eff = PW'(1);
        end else if (int'(r_pages) > MAX_PAGES) begin
            p_eff = PW'(MAX_PAGES);
        end else begin
            p_eff = PW'(r_pages);
        end
    end

    // Config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= rtpf_pkg::WIDTH_RST_VAL;
            r_pages <= rtpf_pkg::PAGES_RST_VAL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rtpf_pkg::CFG_WIDTH: r_width <= i_cfg_data;
                rtpf_pkg::CFG_PAGES: r_pages <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Pixel address, bit merge for the write path
    always_comb begin
        is_write  = (r_func == rtpf_pkg::FUNC_WRITE);
        limit     = LW'(w_eff) * LW'(p_eff);
        pix_addr  = r_base + AW'(r_col);
        bit_mask  = DATW'(1) << r_bit;
        merged    = r_shift[DATW-1] ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
        slot_free = !r_out_valid || o_rsp.ready;
        div_start = (r_state == S_CHECK) &&
                    (CMPW'(r_offset) < CMPW'(limit));
    end

    // RAM port: clearing sweep, or pixel read then write
    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = pix_addr;
        ram_wdata = merged;
        case (r_state)
            S_CLEAR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
            end
            S_RD: begin
                ram_en = 1'b1;
            end
            S_WR: begin
                ram_en = is_write;
                ram_we = is_write;
            end
            default: ;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);

    // Sequencer with walker and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Response taken; a response loading in S_FINISH sets valid instead
            if (r_out_valid && o_rsp.ready && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_func   <= i_req.func;
                        r_offset <= i_req.byte_offset;
                        r_shift  <= i_req.write_data;
                        r_state  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_limit <= limit;
                    r_oor   <= !div_start;
                    r_state <= div_start ? S_DIV : S_FINISH;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_bit   <= div_quot[2:0];
                        r_page  <= div_quot[3 +: PGW];
                        r_col   <= CW'(div_rem);
                        r_state <= S_BASE;
                    end
                end
                S_BASE: begin
                    r_base       <= AW'(r_page) * AW'(w_eff);
                    r_start_page <= rtpf_pkg::PAGE_W'(r_page);
                    r_k          <= '0;
                    r_state      <= S_RD;
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    // Write data leaves at the top, gathered pixels enter at the bottom
                    r_shift <= {r_shift[DATW-2:0], ram_rdata[r_bit]};
                    r_k     <= r_k + 1'b1;
                    if (r_k == 3'(rtpf_pkg::PIX_PER_BYTE - 1)) begin
                        r_end_page <= rtpf_pkg::PAGE_W'(r_page);
                        r_state    <= S_FINISH;
                    end else begin
                        r_state <= S_RD;
                        // Step one pixel right, wrapping to the next row
                        if (WW'(r_col) == w_eff - 1'b1) begin
                            r_col <= '0;
                            r_bit <= r_bit + 1'b1;
                            if (r_bit == 3'd7) begin
                                r_page <= r_page + 1'b1;
                                r_base <= r_base + AW'(w_eff);
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                S_FINISH: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_oor   <= r_oor;
                        r_rd_data   <= (r_oor || is_write) ? '0 : r_shift;
                        r_out_first <= r_oor ? '0 : r_start_page;
                        r_out_last  <= r_oor ? '0 : r_end_page;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.read_data    = r_rd_data;
    assign o_rsp.start_page   = r_out_first;
    assign o_rsp.end_page     = r_out_last;
    assign o_rsp.out_of_range = r_out_oor;

    rtpf_div #(
        .DW (DIVW),
        .VW (WW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_offset, 3'b000}),
        .i_divisor  (w_eff),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    rtpf_ram #(
        .WIDTH (DATW),
        .DEPTH (DEPTH)
    ) u_fb_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_WR) |-> (int'(pix_addr) < int'(r_limit)))
        else $error("pixel address beyond the configured framebuffer");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_oor) |->
        (r_rd_data == '0 && r_out_first == '0 && r_out_last == '0))
        else $error("out-of-range response carries nonzero fields");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && slot_free && is_write) |=> (r_rd_data == '0))
        else $error("write response carries read data");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_BASE || r_state == S_RD || r_state == S_WR)
        |-> !r_oor)
        else $error("out-of-range request walking the framebuffer");

endmodule

`default_nettype wire
